>>> rtl/caloc_pkg.sv
// ----------------------------------------------------------------------------
// caloc_pkg
// shared codes, widths and control/status types of the call argument
// location assigner
// ----------------------------------------------------------------------------
package caloc_pkg;

  // item operation codes (s_tuser)
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ARG   = 2'd1,
    OP_END   = 2'd2
  } op_t;

  // value type codes
  localparam logic [3:0] TK_VOID = 4'd0;
  localparam logic [3:0] TK_I32  = 4'd1;
  localparam logic [3:0] TK_I64  = 4'd2;
  localparam logic [3:0] TK_PTR  = 4'd3;
  localparam logic [3:0] TK_F32  = 4'd4;
  localparam logic [3:0] TK_F64  = 4'd5;
  localparam logic [3:0] TK_VEC  = 4'd6;
  localparam logic [3:0] TK_HFA  = 4'd7;
  localparam logic [3:0] TK_AGG  = 4'd8;

  // location kind codes
  localparam logic [2:0] LOC_GPR   = 3'd0;
  localparam logic [2:0] LOC_FPR   = 3'd1;
  localparam logic [2:0] LOC_VEC   = 3'd2;
  localparam logic [2:0] LOC_STACK = 3'd3;
  localparam logic [2:0] LOC_SRET  = 3'd4;
  localparam logic [2:0] LOC_ERR   = 3'd5;
  localparam logic [2:0] LOC_TOTAL = 3'd6;

  localparam int          MAX_ARGS_DEF = 16;
  localparam logic [7:0]  MAX_PARTS    = 8'd4;
  localparam logic [7:0]  HFA_LIMIT    = 8'd4;
  localparam logic [3:0]  REG_COUNT    = 4'd8;
  localparam logic [3:0]  SRET_REG     = 4'd8;
  localparam logic [15:0] SLOT_BYTES   = 16'd8;
  localparam logic [15:0] FRAME_ALIGN  = 16'd16;
  localparam logic [15:0] REG_AGG_MAX  = 16'd16;
  localparam logic [15:0] F32_BYTES    = 16'd4;
  localparam logic [15:0] F64_BYTES    = 16'd8;

  localparam int MAX_RESULTS = 4;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 4;

  typedef struct packed {
    logic load;
    logic plan;
    logic emit;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic plan_empty;
    logic last_part;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/call_argument_location_assigner.sv
// ----------------------------------------------------------------------------
// call_argument_location_assigner
// places the return value and arguments of a call signature in registers
// and stack slots
// ----------------------------------------------------------------------------
// usage:
//   input stream s_*: one item per signature element; s_tuser carries the
//   operation (start with return type, argument, end of signature). a
//   signature is a start item, its arguments, then an end item.
//   output stream m_*: the locations of each item, m_tlast on the last
//   location that one item gives. void returns, zero sized aggregates and
//   unused operations give no location.
//   timing: items are taken one at a time; an accepted item is latched,
//   planned in the plan state and handed out in the emit state, and no
//   new item is taken until the last one is committed. the sequencer
//   hands out one location per cycle through a single output register
//   while that register is free, and commits the cursor update for the
//   next item with the last location, or alone when the item gives none.
//   when the receiver holds m_tready low the sequencer waits with the next
//   location, and the next input item is taken while the last location
//   still waits in the output register.
//   reset clears the register and stack cursors, the argument count and
//   the error flag; a start item clears them too, flagging a bad hfa return.
// ----------------------------------------------------------------------------
module call_argument_location_assigner #(
  parameter int MAX_ARGS = caloc_pkg::MAX_ARGS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // type_kind[3:0], type_size[19:4], type_align[35:20], element_kind[39:36],
  // element_count[47:40], ret_by_sret[48], zero fill
  input  logic [caloc_pkg::IN_DATA_W-1:0]  s_tdata,
  // op[1:0]
  input  logic [caloc_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // reg_index[3:0], stack_offset[19:4], part bytes[35:20], arg_number[40:36],
  // zero fill
  output logic [caloc_pkg::OUT_DATA_W-1:0] m_tdata,
  // loc_kind[2:0], for_return[3]
  output logic [caloc_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                             m_tlast
);

  caloc_pkg::cmd_t cmd;
  caloc_pkg::sts_t sts;

  caloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  caloc_dp #(
    .MAX_ARGS (MAX_ARGS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // one item at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // a location is never written over a pending one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // return locations carry argument number zero
  a_ret_argn: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3]) |-> (m_tdata[40:36] == 5'd0))
    else $error("return location with nonzero argument number");

  // error results carry no register and no size
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:0] == caloc_pkg::LOC_ERR)) |->
      ((m_tdata[35:20] == 16'd0) && (m_tdata[3:0] == 4'd0) && m_tlast))
    else $error("malformed error result");

endmodule

>>> rtl/caloc_ctrl.sv
// ----------------------------------------------------------------------------
// caloc_ctrl
// sequencer: accept an item, plan its locations, hand out one result per
// cycle while the output is free, then commit the cursor updates
// ----------------------------------------------------------------------------
module caloc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  caloc_pkg::sts_t    sts,
  output caloc_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PLAN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.plan_empty) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_part) begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/caloc_dp.sv
// ----------------------------------------------------------------------------
// caloc_dp
// datapath: input latch, register and stack cursors, location plan and
// output register
// ----------------------------------------------------------------------------
module caloc_dp #(
  parameter int MAX_ARGS = caloc_pkg::MAX_ARGS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  caloc_pkg::cmd_t                     cmd,
  output caloc_pkg::sts_t                     sts,
  input  logic [caloc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [caloc_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [caloc_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [caloc_pkg::OUT_USER_W-1:0]    m_tuser,
  output logic                                m_tlast
);

  localparam int CW = $clog2(MAX_ARGS + 1);
  localparam int RW = caloc_pkg::RES_W;

  // latched item
  logic [1:0]  in_op;
  logic [3:0]  in_kind;
  logic [15:0] in_size;
  logic [15:0] in_align;
  logic [3:0]  in_ek;
  logic [7:0]  in_cnt;
  logic        in_sret;

  // call state
  logic [3:0]    nir;
  logic [3:0]    nfr;
  logic [15:0]   cursor;
  logic [CW-1:0] argc;
  logic          failed;

  // registered plan
  logic [RW-1:0] p_count;
  logic [RW-1:0] p_idx;
  logic [2:0]    p_loc;
  logic [3:0]    p_base;
  logic [15:0]   p_off;
  logic [15:0]   p_psize;
  logic [15:0]   p_lsize;
  logic [15:0]   p_size8;
  logic          p_ret;
  logic [3:0]    p_nir;
  logic [3:0]    p_nfr;
  logic          p_stack;
  logic          p_inc;
  logic          p_fail;
  logic          p_clear;

  // plan logic
  logic [RW-1:0] pl_count;
  logic [2:0]    pl_loc;
  logic [3:0]    pl_base;
  logic [15:0]   pl_psize;
  logic [15:0]   pl_lsize;
  logic          pl_ret;
  logic [3:0]    pl_nir;
  logic [3:0]    pl_nfr;
  logic          pl_stack;
  logic          pl_show_off;
  logic          pl_inc;
  logic          pl_fail;
  logic          pl_clear;
  logic [15:0]   a_sel;
  logic [15:0]   a_eff;
  logic [15:0]   off_round;

  logic          is_int;
  logic          is_flt;
  logic          hfa_ok;
  logic [15:0]   hfa_el_bytes;
  logic [1:0]    agg_parts;
  logic [15:0]   agg_last;
  logic [15:0]   scal_align;
  logic          hfa_fits;
  logic          agg_fits;
  logic          out_last;

  assign is_int    = (in_kind == caloc_pkg::TK_I32) || (in_kind == caloc_pkg::TK_I64) ||
                     (in_kind == caloc_pkg::TK_PTR);
  assign is_flt    = (in_kind == caloc_pkg::TK_F32) || (in_kind == caloc_pkg::TK_F64);
  assign hfa_ok    = ((in_ek == caloc_pkg::TK_F32) || (in_ek == caloc_pkg::TK_F64)) &&
                     (in_cnt != 8'd0) && (in_cnt <= caloc_pkg::MAX_PARTS) &&
                     (in_cnt <= caloc_pkg::HFA_LIMIT);
  assign hfa_el_bytes = (in_ek == caloc_pkg::TK_F32) ? caloc_pkg::F32_BYTES
                                                     : caloc_pkg::F64_BYTES;
  // aggregates of up to 16 bytes split into 8 byte parts
  assign agg_parts = (in_size == 16'd0) ? 2'd0 :
                     (in_size <= caloc_pkg::SLOT_BYTES) ? 2'd1 : 2'd2;
  assign agg_last  = (agg_parts == 2'd2) ? (in_size - caloc_pkg::SLOT_BYTES) : in_size;
  assign scal_align = (in_size >= caloc_pkg::FRAME_ALIGN) ? caloc_pkg::FRAME_ALIGN
                                                          : caloc_pkg::SLOT_BYTES;
  assign hfa_fits  = ({5'd0, nfr} + {1'b0, in_cnt}) <= {5'd0, caloc_pkg::REG_COUNT};
  assign agg_fits  = ({1'b0, nir} + {3'd0, agg_parts}) <= {1'b0, caloc_pkg::REG_COUNT};

  always_comb begin
    pl_count    = '0;
    pl_loc      = caloc_pkg::LOC_GPR;
    pl_base     = '0;
    pl_psize    = '0;
    pl_lsize    = '0;
    pl_ret      = 1'b0;
    pl_nir      = nir;
    pl_nfr      = nfr;
    pl_stack    = 1'b0;
    pl_show_off = 1'b0;
    pl_inc      = 1'b0;
    pl_fail     = 1'b0;
    pl_clear    = 1'b0;
    a_sel       = in_align;
    unique case (in_op)
      caloc_pkg::OP_START: begin
        pl_clear = 1'b1;
        pl_ret   = 1'b1;
        pl_count = RW'(1);
        pl_psize = in_size;
        pl_lsize = in_size;
        priority if (in_sret || (in_kind > caloc_pkg::TK_AGG) ||
                     ((in_kind == caloc_pkg::TK_AGG) && (in_size > caloc_pkg::REG_AGG_MAX))) begin
          pl_loc  = caloc_pkg::LOC_SRET;
          pl_base = caloc_pkg::SRET_REG;
        end else if (is_int) begin
          pl_loc = caloc_pkg::LOC_GPR;
        end else if (is_flt) begin
          pl_loc = caloc_pkg::LOC_FPR;
        end else if (in_kind == caloc_pkg::TK_VEC) begin
          pl_loc = caloc_pkg::LOC_VEC;
        end else if (in_kind == caloc_pkg::TK_HFA) begin
          if (!hfa_ok) begin
            pl_loc   = caloc_pkg::LOC_ERR;
            pl_psize = '0;
            pl_lsize = '0;
            pl_fail  = 1'b1;
          end else begin
            pl_loc   = caloc_pkg::LOC_FPR;
            pl_count = RW'(in_cnt);
            pl_psize = hfa_el_bytes;
            pl_lsize = hfa_el_bytes;
          end
        end else if (in_kind == caloc_pkg::TK_AGG) begin
          pl_loc   = caloc_pkg::LOC_GPR;
          pl_count = RW'(agg_parts);
          pl_psize = caloc_pkg::SLOT_BYTES;
          pl_lsize = agg_last;
        end else begin
          // void return has no location
          pl_count = '0;
        end
      end
      caloc_pkg::OP_ARG: begin
        pl_count = RW'(1);
        pl_psize = in_size;
        pl_lsize = in_size;
        priority if (failed) begin
          pl_loc   = caloc_pkg::LOC_ERR;
          pl_psize = '0;
          pl_lsize = '0;
        end else if ((argc >= CW'(MAX_ARGS)) ||
                     ((in_kind == caloc_pkg::TK_HFA) && !hfa_ok)) begin
          pl_loc   = caloc_pkg::LOC_ERR;
          pl_psize = '0;
          pl_lsize = '0;
          pl_fail  = 1'b1;
        end else begin
          pl_inc = 1'b1;
          priority if (is_int) begin
            if (nir < caloc_pkg::REG_COUNT) begin
              pl_loc  = caloc_pkg::LOC_GPR;
              pl_base = nir;
              pl_nir  = nir + 4'd1;
            end else begin
              pl_loc      = caloc_pkg::LOC_STACK;
              pl_stack    = 1'b1;
              pl_show_off = 1'b1;
              a_sel       = scal_align;
            end
          end else if (is_flt || (in_kind == caloc_pkg::TK_VEC)) begin
            if (nfr < caloc_pkg::REG_COUNT) begin
              pl_loc  = is_flt ? caloc_pkg::LOC_FPR : caloc_pkg::LOC_VEC;
              pl_base = nfr;
              pl_nfr  = nfr + 4'd1;
            end else begin
              pl_loc      = caloc_pkg::LOC_STACK;
              pl_stack    = 1'b1;
              pl_show_off = 1'b1;
              a_sel       = scal_align;
            end
          end else if (in_kind == caloc_pkg::TK_HFA) begin
            if (hfa_fits) begin
              pl_loc   = caloc_pkg::LOC_FPR;
              pl_base  = nfr;
              pl_count = RW'(in_cnt);
              pl_psize = hfa_el_bytes;
              pl_lsize = hfa_el_bytes;
              pl_nfr   = nfr + in_cnt[3:0];
            end else begin
              pl_nfr      = caloc_pkg::REG_COUNT;
              pl_loc      = caloc_pkg::LOC_STACK;
              pl_stack    = 1'b1;
              pl_show_off = 1'b1;
            end
          end else if ((in_kind == caloc_pkg::TK_AGG) &&
                       (in_size <= caloc_pkg::REG_AGG_MAX)) begin
            if (agg_fits) begin
              pl_loc   = caloc_pkg::LOC_GPR;
              pl_base  = nir;
              pl_count = RW'(agg_parts);
              pl_psize = caloc_pkg::SLOT_BYTES;
              pl_lsize = agg_last;
              pl_nir   = nir + {2'd0, agg_parts};
            end else begin
              pl_nir      = caloc_pkg::REG_COUNT;
              pl_loc      = caloc_pkg::LOC_STACK;
              pl_stack    = 1'b1;
              pl_show_off = 1'b1;
            end
          end else begin
            // large aggregates, void and unknown kinds go to memory
            pl_loc      = caloc_pkg::LOC_STACK;
            pl_stack    = 1'b1;
            pl_show_off = 1'b1;
          end
        end
      end
      caloc_pkg::OP_END: begin
        pl_count = RW'(1);
        if (failed) begin
          pl_loc = caloc_pkg::LOC_ERR;
        end else begin
          pl_loc      = caloc_pkg::LOC_TOTAL;
          pl_show_off = 1'b1;
          a_sel       = caloc_pkg::FRAME_ALIGN;
        end
      end
      default: begin
        pl_count = '0;
      end
    endcase
  end

  // stack slot alignment is at least 8, rounding by mask
  assign a_eff     = (a_sel < caloc_pkg::SLOT_BYTES) ? caloc_pkg::SLOT_BYTES : a_sel;
  assign off_round = (cursor + a_eff - 16'd1) & ~(a_eff - 16'd1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_kind  <= s_tdata[3:0];
      in_size  <= s_tdata[19:4];
      in_align <= s_tdata[35:20];
      in_ek    <= s_tdata[39:36];
      in_cnt   <= s_tdata[47:40];
      in_sret  <= s_tdata[48];
      in_op    <= s_tuser[1:0];
    end
    if (cmd.plan) begin
      p_count <= pl_count;
      p_loc   <= pl_loc;
      p_base  <= pl_base;
      p_off   <= pl_show_off ? off_round : 16'd0;
      p_psize <= pl_psize;
      p_lsize <= pl_lsize;
      p_size8 <= (in_size + 16'd7) & ~16'd7;
      p_ret   <= pl_ret;
      p_nir   <= pl_nir;
      p_nfr   <= pl_nfr;
      p_stack <= pl_stack;
      p_inc   <= pl_inc;
      p_fail  <= pl_fail;
      p_clear <= pl_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nir    <= '0;
      nfr    <= '0;
      cursor <= '0;
      argc   <= '0;
      failed <= 1'b0;
      p_idx  <= '0;
    end else begin
      if (cmd.plan) begin
        p_idx <= '0;
      end else if (cmd.emit) begin
        p_idx <= p_idx + RW'(1);
      end
      if (cmd.commit) begin
        if (p_clear) begin
          nir    <= '0;
          nfr    <= '0;
          cursor <= '0;
          argc   <= '0;
          failed <= p_fail;
        end else begin
          nir    <= p_nir;
          nfr    <= p_nfr;
          if (p_stack) begin
            cursor <= p_off + p_size8;
          end
          if (p_inc) begin
            argc <= argc + CW'(1);
          end
          failed <= failed | p_fail;
        end
      end
    end
  end

  assign out_last       = (p_idx == (p_count - RW'(1)));
  assign sts.plan_empty = (p_count == '0);
  assign sts.last_part  = out_last;
  assign sts.out_free   = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata[3:0]   <= p_base + 4'(p_idx);
      m_tdata[19:4]  <= p_off;
      m_tdata[35:20] <= out_last ? p_lsize : p_psize;
      m_tdata[40:36] <= p_ret ? 5'd0 : 5'(argc);
      m_tdata[47:41] <= '0;
      m_tuser[2:0]   <= p_loc;
      m_tuser[3]     <= p_ret;
      m_tlast        <= out_last;
    end
  end

endmodule
